// ----- rtl/vrra_pkg.sv -----
// Package with the shared types and constants of the variable record ring allocator.
`timescale 1ns / 1ps

package vrra_pkg;

    localparam int SIZE_W   = 12;   // payload size field
    localparam int CFG_W    = 13;   // capacity register
    localparam int OFF_W    = 12;   // payload offset field
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 13;   // header plus payload
    localparam int MIN_CAP  = 16;

    localparam logic [CFG_W-1:0] CAP_RESET = 13'd4096;

    typedef enum logic [1:0] {
        OP_RESERVE = 2'd0,
        OP_COMMIT  = 2'd1,
        OP_READ    = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK              = 3'd0,
        STS_TOO_LARGE       = 3'd1,
        STS_NO_SPACE        = 3'd2,
        STS_EMPTY           = 3'd3,
        STS_NOTHING_PENDING = 3'd4
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

endpackage

// ----- rtl/variable_record_ring_allocator.sv -----
// Space manager for a byte ring of variable-length records with a record size memory.
`timescale 1ns / 1ps

// Each item takes two steps: at the edge that accepts it the size memory is read at the
// read position, and in the next cycle the operation is decided and the positions and the
// memory are updated. The result appears on status, payload_offset and record_size for one
// cycle with done high, in the same cycle in which busy falls, and no new item is accepted
// before that. Results cannot be held off; the receiver must take each one when done is high.
// Writing capacity_bytes empties the ring and is meant for an idle block only.
module variable_record_ring_allocator
    import vrra_pkg::*;
#(
    parameter int CAPACITY     = 4096,
    parameter int HEADER_BYTES = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    capacity_bytes,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          opcode,
    input  logic [SIZE_W-1:0]   payload_size,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [OFF_W-1:0]    payload_offset,
    output logic [SIZE_W-1:0]   record_size
);

    localparam int POS_W = $clog2(CAPACITY);
    localparam int CAP_W = $clog2(CAPACITY + 1);
    // Working width for sums of a position and a record length.
    localparam int CW    = (CAP_W + 1 > CFG_W + 1) ? CAP_W + 1 : CFG_W + 1;
    localparam int WRAP_RESET = (CAPACITY < 4096) ? CAPACITY : 4096;

    // Saturates a capacity register value to the range the ring can use.
    function automatic logic [CW-1:0] sat_cap(input logic [CFG_W-1:0] v);
        logic [CW-1:0] c;
        c = CW'(v);
        if (c < CW'(MIN_CAP))
        begin
            c = CW'(MIN_CAP);
        end
        if (c > CW'(CAPACITY))
        begin
            c = CW'(CAPACITY);
        end
        return c;
    endfunction

    // Payload offset of the record whose header sits at pos.
    function automatic logic [OFF_W-1:0] pay_off(input logic [CW-1:0] pos,
                                                 input logic [CW-1:0] cap);
        logic [CW-1:0] o;
        o = pos + CW'(HEADER_BYTES);
        if (o >= cap)
        begin
            o = o - cap;
        end
        return o[OFF_W-1:0];
    endfunction

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [CFG_W-1:0]      cap_reg, cap_next;
    logic [POS_W-1:0]      write_position_reg, write_position_next;
    logic [POS_W-1:0]      read_position_reg, read_position_next;
    logic [POS_W-1:0]      reserved_position_reg, reserved_position_next;
    logic [TOTAL_W-1:0]    reserved_total_reg, reserved_total_next;
    logic                  pending_reg, pending_next;
    logic [CAP_W-1:0]      wrap_mark_reg, wrap_mark_next;
    logic                  done_reg, done_next;
    status_t               status_reg, status_next;
    logic [OFF_W-1:0]      offset_reg, offset_next;
    logic [SIZE_W-1:0]     rsize_reg, rsize_next;

    // Size memory, indexed by header position.
    logic [SIZE_W-1:0]     size_mem [CAPACITY];
    logic [SIZE_W-1:0]     mem_rd_data_reg;
    logic                  mem_we;
    logic [POS_W-1:0]      mem_wr_addr;

    logic [CW-1:0]         cap_c;
    logic [CW-1:0]         w_x, r_x, rp_x, total_x, wrap_x;
    logic [CW-1:0]         res_end, com_end, rel_end;
    logic [TOTAL_W-1:0]    com_size;
    logic                  accept;

    assign accept  = start && (state_reg == ST_IDLE);
    assign cap_c   = sat_cap(cap_reg);
    assign w_x     = CW'(write_position_reg);
    assign r_x     = CW'(read_position_reg);
    assign rp_x    = CW'(reserved_position_reg);
    assign wrap_x  = CW'(wrap_mark_reg);
    assign total_x = CW'(HEADER_BYTES) + CW'(size_reg);
    assign res_end = w_x + total_x;
    assign com_end = rp_x + CW'(reserved_total_reg);
    assign rel_end = r_x + CW'(HEADER_BYTES) + CW'(mem_rd_data_reg);
    assign com_size = reserved_total_reg - TOTAL_W'(HEADER_BYTES);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            size_mem[mem_wr_addr] <= size_reg;
        end
        mem_rd_data_reg <= size_mem[read_position_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= ST_IDLE;
            op_reg                <= OP_RESERVE;
            size_reg              <= '0;
            cap_reg               <= CAP_RESET;
            write_position_reg    <= '0;
            read_position_reg     <= '0;
            reserved_position_reg <= '0;
            reserved_total_reg    <= '0;
            pending_reg           <= 1'b0;
            wrap_mark_reg         <= CAP_W'(WRAP_RESET);
            done_reg              <= 1'b0;
            status_reg            <= STS_OK;
            offset_reg            <= '0;
            rsize_reg             <= '0;
        end
        else
        begin
            state_reg             <= state_next;
            op_reg                <= op_next;
            size_reg              <= size_next;
            cap_reg               <= cap_next;
            write_position_reg    <= write_position_next;
            read_position_reg     <= read_position_next;
            reserved_position_reg <= reserved_position_next;
            reserved_total_reg    <= reserved_total_next;
            pending_reg           <= pending_next;
            wrap_mark_reg         <= wrap_mark_next;
            done_reg              <= done_next;
            status_reg            <= status_next;
            offset_reg            <= offset_next;
            rsize_reg             <= rsize_next;
        end
    end

    always_comb
    begin
        logic          ok;
        logic [CW-1:0] at;
        logic [CW-1:0] nw;
        logic [CW-1:0] nr;

        ok = 1'b0;
        at = '0;
        nw = '0;
        nr = '0;

        state_next             = state_reg;
        op_next                = op_reg;
        size_next              = size_reg;
        cap_next               = cap_reg;
        write_position_next    = write_position_reg;
        read_position_next     = read_position_reg;
        reserved_position_next = reserved_position_reg;
        reserved_total_next    = reserved_total_reg;
        pending_next           = pending_reg;
        wrap_mark_next         = wrap_mark_reg;
        done_next              = 1'b0;
        status_next            = status_reg;
        offset_next            = offset_reg;
        rsize_next             = rsize_reg;
        mem_we                 = 1'b0;
        mem_wr_addr            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = op_t'(opcode);
                    size_next  = payload_size;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next  = ST_IDLE;
                done_next   = 1'b1;
                status_next = STS_OK;
                offset_next = '0;
                rsize_next  = '0;
                case (op_reg)
                    OP_RESERVE:
                    begin
                        if (total_x > cap_c)
                        begin
                            status_next = STS_TOO_LARGE;
                        end
                        else if (w_x >= r_x)
                        begin
                            if (total_x <= cap_c - w_x)
                            begin
                                nw = (res_end >= cap_c) ? '0 : res_end;
                                at = w_x;
                                // Committing must not land the writer on a live reader.
                                ok = !((nw == r_x) && (w_x != r_x));
                            end
                            else if (total_x <= r_x)
                            begin
                                at = '0;
                                ok = !((total_x == r_x) && (w_x != r_x));
                            end
                            if (!ok)
                            begin
                                status_next = STS_NO_SPACE;
                            end
                        end
                        else
                        begin
                            if (total_x < r_x - w_x)
                            begin
                                at = w_x;
                                ok = 1'b1;
                            end
                            else
                            begin
                                status_next = STS_NO_SPACE;
                            end
                        end
                        if (ok)
                        begin
                            mem_we                 = 1'b1;
                            mem_wr_addr            = POS_W'(at);
                            reserved_position_next = POS_W'(at);
                            reserved_total_next    = total_x[TOTAL_W-1:0];
                            pending_next           = 1'b1;
                            offset_next            = pay_off(at, cap_c);
                            rsize_next             = size_reg;
                        end
                    end
                    OP_COMMIT:
                    begin
                        if (!pending_reg)
                        begin
                            status_next = STS_NOTHING_PENDING;
                        end
                        else
                        begin
                            nw = (com_end >= cap_c) ? '0 : com_end;
                            // A reservation placed at 0 marks where the writer wrapped.
                            if (rp_x != w_x)
                            begin
                                if (r_x == w_x)
                                begin
                                    read_position_next = '0;
                                end
                                else
                                begin
                                    wrap_mark_next = CAP_W'(w_x);
                                end
                            end
                            write_position_next = POS_W'(nw);
                            pending_next        = 1'b0;
                            offset_next         = pay_off(rp_x, cap_c);
                            rsize_next          = com_size[SIZE_W-1:0];
                        end
                    end
                    default:
                    begin
                        if (r_x == w_x)
                        begin
                            status_next = STS_EMPTY;
                        end
                        else
                        begin
                            rsize_next  = mem_rd_data_reg;
                            offset_next = pay_off(r_x, cap_c);
                            if (op_reg == OP_RELEASE)
                            begin
                                nr = ((rel_end >= cap_c) || (rel_end == wrap_x)) ? '0 : rel_end;
                                if (nr == '0)
                                begin
                                    wrap_mark_next = CAP_W'(cap_c);
                                end
                                read_position_next = POS_W'(nr);
                            end
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A capacity write empties the ring.
        if (cfg_wr_en)
        begin
            cap_next               = capacity_bytes;
            write_position_next    = '0;
            read_position_next     = '0;
            reserved_position_next = '0;
            reserved_total_next    = '0;
            pending_next           = 1'b0;
            wrap_mark_next         = CAP_W'(sat_cap(capacity_bytes));
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign payload_offset = offset_reg;
    assign record_size    = rsize_reg;

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the variable record ring allocator: directed table, then predicted random items.
`timescale 1ns / 1ps

module tb_top;
    import vrra_pkg::*;

    localparam int RING_CAP  = 4096;
    localparam int HDR_BYTES = 8;
    localparam int PHASES    = 12;
    localparam int PHASE_LEN = 150;

    typedef struct packed {
        status_t           sts;
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] rsize;
    } reply_t;

    typedef struct {
        bit                is_cfg;
        op_t               op;
        int                value;
        bit                typed;
        reply_t            rep;
    } opening_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]    capacity_bytes = '0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          opcode = OP_READ;
    logic [SIZE_W-1:0]   payload_size = '0;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    payload_offset;
    logic [SIZE_W-1:0]   record_size;

    // Predictor copy of the ring state.
    logic [CFG_W-1:0]    cap_reg;
    logic [11:0]         wr_pos;
    logic [11:0]         rd_pos;
    logic [11:0]         resv_pos;
    logic [TOTAL_W-1:0]  resv_total;
    logic                resv_open;
    logic [12:0]         wrap_at;
    logic [SIZE_W-1:0]   size_mem [RING_CAP];
    bit                  size_written [RING_CAP];

    reply_t              ring_replies [$];
    reply_t              typed_reply;
    bit                  typed_valid = 1'b0;
    bit                  item_taken = 1'b0;
    reply_t              want;
    reply_t              got;
    opening_row_t        opening_rows [$];

    int                  fail_count = 0;
    int                  items_in = 0;
    int                  results_out = 0;
    int                  cfg_writes = 0;
    int                  status_seen [8];

    variable_record_ring_allocator #(
        .CAPACITY     (RING_CAP),
        .HEADER_BYTES (HDR_BYTES)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .capacity_bytes (capacity_bytes),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .payload_size   (payload_size),
        .done           (done),
        .status         (status),
        .payload_offset (payload_offset),
        .record_size    (record_size)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int ring_cap();
        int c;
        c = int'(cap_reg);
        if (c < MIN_CAP)
            c = MIN_CAP;
        if (c > RING_CAP)
            c = RING_CAP;
        return c;
    endfunction

    function automatic void ring_empty();
        wr_pos     = '0;
        rd_pos     = '0;
        resv_pos   = '0;
        resv_total = '0;
        resv_open  = 1'b0;
        wrap_at    = 13'(ring_cap());
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(input opening_row_t row);
        opening_rows = {opening_rows, row};
    endfunction

    function automatic logic [OFF_W-1:0] payload_at(int pos, int cap);
        int o;
        o = pos + HDR_BYTES;
        if (o >= cap)
            o -= cap;
        return OFF_W'(o);
    endfunction

    // Works out the reply to one item and advances the predicted ring state.
    function automatic reply_t alloc_step(op_t op, logic [SIZE_W-1:0] psize);
        int     cap;
        int     w;
        int     r;
        int     total;
        int     at;
        int     nw;
        int     nr;
        bit     ok;
        reply_t rep;
        cap = ring_cap();
        w   = int'(wr_pos);
        r   = int'(rd_pos);
        rep = '{STS_OK, '0, '0};
        ok  = 1'b0;
        at  = 0;
        case (op)
            OP_RESERVE:
            begin
                total = HDR_BYTES + int'(psize);
                if (total > cap)
                    rep.sts = STS_TOO_LARGE;
                else if (w >= r)
                begin
                    if (total <= cap - w)
                    begin
                        nw = w + total;
                        if (nw >= cap)
                            nw = 0;
                        at = w;
                        // Refuse a record whose commit would make a nonempty ring look empty.
                        ok = !(nw == r && w != r);
                    end
                    else if (total <= r)
                    begin
                        at = 0;
                        ok = !(total == r && w != r);
                    end
                    if (!ok)
                        rep.sts = STS_NO_SPACE;
                end
                else if (total < r - w)
                begin
                    at = w;
                    ok = 1'b1;
                end
                else
                    rep.sts = STS_NO_SPACE;
                if (ok)
                begin
                    size_mem[at]     = psize;
                    size_written[at] = 1'b1;
                    resv_pos         = 12'(at);
                    resv_total       = TOTAL_W'(total);
                    resv_open        = 1'b1;
                    rep.offset       = payload_at(at, cap);
                    rep.rsize        = psize;
                end
            end
            OP_COMMIT:
            begin
                if (!resv_open)
                    rep.sts = STS_NOTHING_PENDING;
                else
                begin
                    nw = int'(resv_pos) + int'(resv_total);
                    if (nw >= cap)
                        nw = 0;
                    // A wrapped record restarts an empty ring or leaves a mark for the reader.
                    if (int'(resv_pos) != w)
                    begin
                        if (r == w)
                            rd_pos = '0;
                        else
                            wrap_at = 13'(w);
                    end
                    wr_pos     = 12'(nw);
                    resv_open  = 1'b0;
                    rep.offset = payload_at(int'(resv_pos), cap);
                    rep.rsize  = SIZE_W'(int'(resv_total) - HDR_BYTES);
                end
            end
            default:
            begin
                if (r == w)
                    rep.sts = STS_EMPTY;
                else
                begin
                    rep.rsize  = size_mem[r];
                    rep.offset = payload_at(r, cap);
                    if (op == OP_RELEASE)
                    begin
                        nr = r + HDR_BYTES + int'(rep.rsize);
                        if (nr >= cap || nr == int'(wrap_at))
                            nr = 0;
                        if (nr == 0)
                            wrap_at = 13'(cap);
                        rd_pos = 12'(nr);
                    end
                end
            end
        endcase
        return rep;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                got = '{status_t'(status), payload_offset, record_size};
                if (ring_replies.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with no item awaiting it: status %0d offset %0d size %0d",
                             $time, status, payload_offset, record_size);
                end
                else
                begin
                    want = ring_replies.pop_front();
                    results_out++;
                    status_seen[status]++;
                    if (got.sts != want.sts)
                    begin
                        fail_count++;
                        $display("%0t: status expected %0d actual %0d", $time, want.sts, got.sts);
                    end
                    if (got.offset != want.offset)
                    begin
                        fail_count++;
                        $display("%0t: payload_offset expected %0d actual %0d",
                                 $time, want.offset, got.offset);
                    end
                    if (got.rsize != want.rsize)
                    begin
                        fail_count++;
                        $display("%0t: record_size expected %0d actual %0d",
                                 $time, want.rsize, got.rsize);
                    end
                end
            end
            if (cfg_wr_en)
            begin
                cap_reg = capacity_bytes;
                ring_empty();
            end
            if (start && !busy)
            begin
                want = alloc_step(op_t'(opcode), payload_size);
                if (typed_valid)
                    want = typed_reply;
                ring_replies = {ring_replies, want};
                items_in++;
                item_taken = 1'b1;
            end
        end
    end

    // Presents one item from a falling edge and returns at the falling edge after it is taken.
    task automatic send_item(input op_t op, input logic [SIZE_W-1:0] sz,
                             input bit typed, input reply_t rep);
        start        = 1'b1;
        opcode       = op;
        payload_size = sz;
        typed_valid  = typed;
        typed_reply  = rep;
        do
            @(negedge clk);
        while (!item_taken);
        item_taken = 1'b0;
    endtask

    // The register is only written once every reply has come back.
    task automatic set_capacity(input int value);
        start = 1'b0;
        while (ring_replies.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
        cfg_wr_en      = 1'b1;
        capacity_bytes = CFG_W'(value);
        @(negedge clk);
        cfg_wr_en = 1'b0;
        cfg_writes++;
    endtask

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d replies outstanding", ring_replies.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int                cap;
        int                idle_pct;
        int                n;
        int                k;
        int                pick;
        op_t               op;
        logic [SIZE_W-1:0] sz;
        reply_t            none;

        none    = '{STS_OK, '0, '0};
        cap_reg = CAP_RESET;
        ring_empty();
        foreach (size_written[i])
            size_written[i] = 1'b0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        add_row('{0, OP_READ,    0,    1, '{STS_EMPTY, 12'd0, 12'd0}});
        add_row('{0, OP_COMMIT,  0,    1, '{STS_NOTHING_PENDING, 12'd0, 12'd0}});
        add_row('{0, OP_RESERVE, 4095, 1, '{STS_TOO_LARGE, 12'd0, 12'd0}});
        add_row('{0, OP_RESERVE, 4089, 1, '{STS_TOO_LARGE, 12'd0, 12'd0}});
        add_row('{0, OP_RESERVE, 4088, 1, '{STS_OK, 12'd8, 12'd4088}});
        add_row('{0, OP_RESERVE, 0,    1, '{STS_OK, 12'd8, 12'd0}});
        add_row('{0, OP_COMMIT,  0,    1, '{STS_OK, 12'd8, 12'd0}});
        add_row('{0, OP_RELEASE, 0,    0, none});
        // Capacity below the minimum saturates to 16 bytes.
        add_row('{1, OP_READ,    0,    0, none});
        add_row('{0, OP_RESERVE, 9,    1, '{STS_TOO_LARGE, 12'd0, 12'd0}});
        add_row('{0, OP_RESERVE, 8,    1, '{STS_OK, 12'd8, 12'd8}});
        add_row('{0, OP_COMMIT,  0,    0, none});
        // A 64-byte ring: wrap to zero, replaced reservation, wrap mark and the full-ring refusals.
        add_row('{1, OP_READ,    64,   0, none});
        add_row('{0, OP_RESERVE, 24,   0, none});
        add_row('{0, OP_COMMIT,  0,    0, none});
        add_row('{0, OP_RESERVE, 8,    0, none});
        add_row('{0, OP_COMMIT,  0,    0, none});
        add_row('{0, OP_RELEASE, 0,    0, none});
        add_row('{0, OP_RESERVE, 16,   0, none});
        add_row('{0, OP_RESERVE, 0,    0, none});
        add_row('{0, OP_RESERVE, 16,   0, none});
        add_row('{0, OP_COMMIT,  0,    0, none});
        add_row('{0, OP_RESERVE, 0,    1, '{STS_NO_SPACE, 12'd0, 12'd0}});
        add_row('{0, OP_READ,    0,    0, none});
        add_row('{0, OP_RELEASE, 0,    0, none});
        add_row('{0, OP_RESERVE, 24,   0, none});
        add_row('{0, OP_COMMIT,  0,    0, none});
        add_row('{0, OP_RELEASE, 0,    0, none});
        add_row('{0, OP_RESERVE, 16,   1, '{STS_NO_SPACE, 12'd0, 12'd0}});

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (opening_rows[i])
        begin
            if (opening_rows[i].is_cfg)
                set_capacity(opening_rows[i].value);
            else
                send_item(opening_rows[i].op, SIZE_W'(opening_rows[i].value),
                          opening_rows[i].typed, opening_rows[i].rep);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 0)
                set_capacity(0);
            else if (ph == 1)
                set_capacity(8191);
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    set_capacity($urandom_range(16, 160));
                else if (pick == 6)
                    set_capacity($urandom_range(161, 4096));
                else if (pick == 7)
                    set_capacity($urandom_range(0, 1) ? $urandom_range(0, 17)
                                                      : $urandom_range(4095, 4097));
                else
                    set_capacity($urandom & 32'h1fff);
            end
            cap = ring_cap();
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 15;
                default: idle_pct = 40;
            endcase
            if (ph == PHASES - 1)
                idle_pct = 0;

            n = 0;
            while (n < PHASE_LEN)
            begin
                if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                begin
                    start = 1'b0;
                    repeat ($urandom_range(1, 18)) @(negedge clk);
                end
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    sz = SIZE_W'($urandom_range(0, cap / 4));
                else if (pick < 80)
                    sz = SIZE_W'($urandom);
                else if (pick < 85)
                    sz = '0;
                else if (pick < 90)
                    sz = '1;
                else if (pick < 95)
                    sz = SIZE_W'(cap - HDR_BYTES);
                else
                    sz = SIZE_W'(cap - HDR_BYTES + 1);

                k = $urandom_range(0, 99);
                if (k < 40)
                begin
                    send_item(OP_RESERVE, sz, 1'b0, none);
                    send_item(OP_COMMIT, SIZE_W'($urandom), 1'b0, none);
                    n += 2;
                end
                else
                begin
                    if (k < 75)
                        op = OP_RELEASE;
                    else if (k < 85)
                        op = OP_READ;
                    else if (k < 93)
                        op = OP_RESERVE;
                    else
                        op = OP_COMMIT;
                    // Never let the reader fetch a size entry that was never written.
                    if (op inside {OP_READ, OP_RELEASE} && rd_pos != wr_pos
                        && !size_written[rd_pos])
                        op = OP_COMMIT;
                    send_item(op, (op == OP_RESERVE) ? sz : SIZE_W'($urandom), 1'b0, none);
                    n++;
                end
            end
        end

        start = 1'b0;
        while (ring_replies.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Ran %0d items with %0d replies checked across %0d capacity settings.",
                 items_in, results_out, cfg_writes);
        $display("Replies ok %0d, too large %0d, no space %0d, empty %0d, nothing pending %0d.",
                 status_seen[STS_OK], status_seen[STS_TOO_LARGE], status_seen[STS_NO_SPACE],
                 status_seen[STS_EMPTY], status_seen[STS_NOTHING_PENDING]);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
